// ----- design/dmcp_pkg.sv -----
// Shared types and constants for the decimal money parser.
`timescale 1ns / 1ps

package dmcp_pkg;

  // Width of the signed amount; the magnitude saturates at 2^(VALUE_WIDTH-1)-1.
  localparam int VALUE_WIDTH = 64;
  localparam int MAG_W       = VALUE_WIDTH - 1;
  // Width of the output amount port.
  localparam int CENTS_W     = 64;
  localparam int STATUS_W    = 2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_DIGIT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Characters of interest.
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_POINT = 8'h2E;

  // One accepted input transaction.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       flush;
  } item_t;

endpackage

// ----- design/dmcp_in_stage.sv -----
// Input register stage of the decimal money parser.
`timescale 1ns / 1ps

module dmcp_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dmcp_pkg::item_t item_i,
  output logic          item_valid_o,
  output dmcp_pkg::item_t item_o,
  input  logic          advance_i
);
  import dmcp_pkg::*;

  logic  valid_q;
  item_t item_q;

  // A new transaction is taken whenever the held one leaves or none is held.
  assign in_ready_o   = !valid_q || advance_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  // Valid flag of the held transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload of the held transaction.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- design/dmcp_parse_core.sv -----
// Token state, per-character update and result register of the parser.
`timescale 1ns / 1ps

module dmcp_parse_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  input  dmcp_pkg::item_t               item_i,
  output logic                          advance_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dmcp_pkg::CENTS_W-1:0]  cents_o,
  output logic [dmcp_pkg::STATUS_W-1:0] status_o
);
  import dmcp_pkg::*;

  // Phase codes of the token.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SIGN  = 3'd1;
  localparam logic [2:0] PH_INT   = 3'd2;
  localparam logic [2:0] PH_ZERO  = 3'd3;
  localparam logic [2:0] PH_POINT = 3'd4;
  localparam logic [2:0] PH_FRAC1 = 3'd5;

  // Sum width: ten times the largest magnitude plus 900 fits here.
  localparam int SUM_W = MAG_W + 4;
  localparam logic [MAG_W-1:0] LIM = '1;

  logic [2:0]       phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [MAG_W-1:0] mag_q, mag_d;
  logic             ovf_q, ovf_d;

  logic                out_valid_q;
  logic [CENTS_W-1:0]  cents_q, cents_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                emit;

  // Effective state, with unused phase codes read as idle.
  logic [2:0]       ph;
  logic             cur_neg;
  logic [MAG_W-1:0] cur_mag;
  logic             cur_ovf;

  // Character decode.
  logic [7:0]       c;
  logic             is_digit;
  logic             is_sign;
  logic [3:0]       dig;
  logic [SUM_W-1:0] dig_x, add100, add10, add1, mag_x;
  logic [SUM_W-1:0] sum_int, sum_frac1, sum_frac2;
  logic             sat_int, sat_frac1, sat_frac2;

  // Values handed to the result.
  logic             em_sign;
  logic             em_neg;
  logic [MAG_W-1:0] em_mag;
  logic             em_ovf;
  logic             start;
  logic [CENTS_W-1:0] em_val;

  // The held transaction moves on when the result register can take a result.
  assign advance_o = item_valid_i && (!out_valid_q || out_ready_i);

  // Decode and the three saturating accumulations.
  always_comb begin
    c        = item_i.char_byte;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    is_sign  = (c == CHAR_MINUS) || (c == CHAR_PLUS);
    dig      = c[3:0];
    dig_x    = SUM_W'(dig);
    add100   = (dig_x << 6) + (dig_x << 5) + (dig_x << 2);
    add10    = (dig_x << 3) + (dig_x << 1);
    add1     = dig_x;

    ph      = (phase_q > PH_FRAC1) ? PH_IDLE : phase_q;
    cur_neg = (phase_q > PH_FRAC1) ? 1'b0 : neg_q;
    cur_mag = (phase_q > PH_FRAC1) ? '0 : mag_q;
    cur_ovf = (phase_q > PH_FRAC1) ? 1'b0 : ovf_q;

    mag_x     = SUM_W'(cur_mag);
    sum_int   = (mag_x << 3) + (mag_x << 1) + add100;
    sum_frac1 = mag_x + add10;
    sum_frac2 = mag_x + add1;
    sat_int   = cur_ovf || (sum_int > SUM_W'(LIM));
    sat_frac1 = cur_ovf || (sum_frac1 > SUM_W'(LIM));
    sat_frac2 = cur_ovf || (sum_frac2 > SUM_W'(LIM));
  end

  // Next token state and whether this transaction gives a result.
  always_comb begin
    phase_d = ph;
    neg_d   = cur_neg;
    mag_d   = cur_mag;
    ovf_d   = cur_ovf;
    emit    = 1'b0;
    start   = 1'b0;
    em_sign = (ph == PH_SIGN);
    em_neg  = cur_neg;
    em_mag  = cur_mag;
    em_ovf  = cur_ovf;

    if (item_i.flush) begin
      // Flush completes an open token; the byte carries nothing.
      if (ph != PH_IDLE) begin
        emit    = 1'b1;
        phase_d = PH_IDLE;
        neg_d   = 1'b0;
        mag_d   = '0;
        ovf_d   = 1'b0;
      end
    end else begin
      unique case (ph)
        PH_IDLE: begin
          start = 1'b1;
        end
        PH_SIGN: begin
          if (is_digit) begin
            if (dig == 4'd0) begin
              phase_d = PH_ZERO;
            end else begin
              phase_d = PH_INT;
              mag_d   = MAG_W'(add100);
            end
          end else begin
            emit  = 1'b1;
            start = 1'b1;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            mag_d = sat_int ? LIM : MAG_W'(sum_int);
            ovf_d = sat_int;
          end else if (c == CHAR_POINT) begin
            phase_d = PH_POINT;
          end else begin
            emit  = 1'b1;
            start = 1'b1;
          end
        end
        PH_ZERO: begin
          if (c == CHAR_POINT) begin
            phase_d = PH_POINT;
          end else begin
            emit  = 1'b1;
            start = 1'b1;
          end
        end
        PH_POINT: begin
          if (is_digit) begin
            mag_d   = sat_frac1 ? LIM : MAG_W'(sum_frac1);
            ovf_d   = sat_frac1;
            phase_d = PH_FRAC1;
          end else begin
            emit  = 1'b1;
            start = 1'b1;
          end
        end
        PH_FRAC1: begin
          if (is_digit) begin
            // Second fraction digit closes the token straight away.
            em_mag  = sat_frac2 ? LIM : MAG_W'(sum_frac2);
            em_ovf  = sat_frac2;
            emit    = 1'b1;
            phase_d = PH_IDLE;
            neg_d   = 1'b0;
            mag_d   = '0;
            ovf_d   = 1'b0;
          end else begin
            emit  = 1'b1;
            start = 1'b1;
          end
        end
        default: begin
          start = 1'b1;
        end
      endcase

      // The byte opens a new token if it is a sign or a digit.
      if (start) begin
        neg_d = 1'b0;
        mag_d = '0;
        ovf_d = 1'b0;
        if (is_sign) begin
          phase_d = PH_SIGN;
          neg_d   = (c == CHAR_MINUS);
        end else if (is_digit) begin
          if (dig == 4'd0) begin
            phase_d = PH_ZERO;
          end else begin
            phase_d = PH_INT;
            mag_d   = MAG_W'(add100);
          end
        end else begin
          phase_d = PH_IDLE;
        end
      end
    end

    // Result value and status.
    em_val  = em_sign ? '0 : CENTS_W'(em_mag);
    cents_d = em_neg ? (CENTS_W'(0) - em_val) : em_val;
    if (em_sign) begin
      status_d = STATUS_NO_DIGIT;
    end else if (em_ovf) begin
      status_d = STATUS_OVERFLOW;
    end else begin
      status_d = STATUS_OK;
    end
  end

  // Token state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (advance_o) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      ovf_q   <= ovf_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (advance_o && emit) begin
      cents_q  <= cents_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cents_o     = cents_q;
  assign status_o    = status_q;

endmodule

// ----- design/decimal_money_to_cents_parser.sv -----
// Top level of the streaming decimal money parser.
`timescale 1ns / 1ps

// Parses an ASCII byte stream into money amounts: an optional sign, integer
// digits (a lone leading zero ends the integer part), an optional point and
// up to two fraction digits. Each token yields a signed count of hundredths
// with a status (ok, sign without digit, or overflow with a saturated
// magnitude). A result appears when a byte ends the token, when the second
// fraction digit arrives, or on a flush transaction. One transaction is taken
// every clock cycle; the per-character multiply by ten and add, with its
// saturation compare, is combinational between the input register and the
// result register, which hold each transaction and its result in turn.
// Throughput drops only while the result register is stalled.
module decimal_money_to_cents_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    char_byte_i,
  input  logic                          flush_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dmcp_pkg::CENTS_W-1:0]  cents_o,
  output logic [dmcp_pkg::STATUS_W-1:0] status_o
);
  import dmcp_pkg::*;

  item_t in_item;
  item_t held_item;
  logic  held_valid;
  logic  advance;

  assign in_item.char_byte = char_byte_i;
  assign in_item.flush     = flush_i;

  // Input register.
  dmcp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .item_valid_o (held_valid),
    .item_o       (held_item),
    .advance_i    (advance)
  );

  // Token state and result register.
  dmcp_parse_core u_parse_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (held_valid),
    .item_i       (held_item),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cents_o      (cents_o),
    .status_o     (status_o)
  );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the streaming decimal money parser.
`timescale 1ns / 1ps

module tb;
  import dmcp_pkg::*;

  // Number of stream bytes that take part in a token; idle noise is not counted.
  localparam int STREAM_ITEMS = 1850;
  // Bytes near the end of the run that are sent with no idling on either side.
  localparam int CALM_TAIL    = 150;
  // Cycles allowed after the last expected result for stray output.
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;

  localparam logic [63:0] MAG_MAX = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

  typedef enum logic [2:0] {
    TOK_IDLE,
    TOK_SIGNED,
    TOK_INT,
    TOK_LEAD_ZERO,
    TOK_POINT,
    TOK_FRAC1
  } token_state_e;

  typedef struct {
    logic [CENTS_W-1:0]  cents;
    logic [STATUS_W-1:0] status;
  } amount_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [7:0]          char_byte_i = 8'h00;
  logic                flush_i     = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [CENTS_W-1:0]  cents_o;
  logic [STATUS_W-1:0] status_o;

  // Predicted parser state.
  token_state_e tok_state = TOK_IDLE;
  logic         tok_neg   = 1'b0;
  logic [63:0]  tok_mag   = '0;
  logic         tok_sat   = 1'b0;

  amount_t expected_amounts[$];
  int      error_count    = 0;
  int      accepted_chars = 0;
  bit      pacing_on      = 1'b1;

  decimal_money_to_cents_parser uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .char_byte_i(char_byte_i),
    .flush_i    (flush_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cents_o    (cents_o),
    .status_o   (status_o)
  );

  // Free-running 100 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Amount predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [63:0] digit_value(input logic [7:0] c);
    return {56'd0, c - CHAR_ZERO};
  endfunction

  // Scales and adds to the running magnitude, pinning it at the maximum once exceeded.
  function automatic void grow_magnitude(input logic [63:0] mul, input logic [63:0] add);
    if (tok_sat || (tok_mag > (MAG_MAX - add) / mul)) begin
      tok_mag = MAG_MAX;
      tok_sat = 1'b1;
    end else begin
      tok_mag = tok_mag * mul + add;
    end
  endfunction

  function automatic void clear_token();
    tok_state = TOK_IDLE;
    tok_neg   = 1'b0;
    tok_mag   = '0;
    tok_sat   = 1'b0;
  endfunction

  // A lone zero closes the integer part straight away.
  function automatic void take_first_digit(input logic [7:0] c);
    if (c == CHAR_ZERO) begin
      tok_state = TOK_LEAD_ZERO;
    end else begin
      tok_state = TOK_INT;
      tok_mag   = digit_value(c) * 64'd100;
    end
  endfunction

  // Opens a new token if the byte can start one; anything else is dropped.
  function automatic void start_token(input logic [7:0] c);
    clear_token();
    if ((c == CHAR_MINUS) || (c == CHAR_PLUS)) begin
      tok_state = TOK_SIGNED;
      tok_neg   = (c == CHAR_MINUS);
    end else if (is_digit(c)) begin
      take_first_digit(c);
    end
  endfunction

  function automatic amount_t token_amount();
    amount_t a;
    a.cents  = tok_mag;
    a.status = tok_sat ? STATUS_OVERFLOW : STATUS_OK;
    if (tok_state == TOK_SIGNED) begin
      a.cents  = '0;
      a.status = STATUS_NO_DIGIT;
    end
    if (tok_neg) begin
      a.cents = -a.cents;
    end
    return a;
  endfunction

  // Advances the predicted state by one transaction; returns 1 when a result is due.
  function automatic bit predict_amount(input logic [7:0] c, input logic fl,
                                        output amount_t res);
    res = token_amount();
    if (fl) begin
      if (tok_state == TOK_IDLE) begin
        return 1'b0;
      end
      clear_token();
      return 1'b1;
    end
    case (tok_state)
      TOK_SIGNED: begin
        if (is_digit(c)) begin
          take_first_digit(c);
          return 1'b0;
        end
      end
      TOK_INT: begin
        if (is_digit(c)) begin
          grow_magnitude(64'd10, digit_value(c) * 64'd100);
          return 1'b0;
        end
        if (c == CHAR_POINT) begin
          tok_state = TOK_POINT;
          return 1'b0;
        end
      end
      TOK_LEAD_ZERO: begin
        if (c == CHAR_POINT) begin
          tok_state = TOK_POINT;
          return 1'b0;
        end
      end
      TOK_POINT: begin
        if (is_digit(c)) begin
          grow_magnitude(64'd1, digit_value(c) * 64'd10);
          tok_state = TOK_FRAC1;
          return 1'b0;
        end
      end
      TOK_FRAC1: begin
        // The second fraction digit completes the token on its own.
        if (is_digit(c)) begin
          grow_magnitude(64'd1, digit_value(c));
          res = token_amount();
          clear_token();
          return 1'b1;
        end
      end
      default: begin
        start_token(c);
        return 1'b0;
      end
    endcase
    // The byte ends the open token and may begin the next one.
    res = token_amount();
    start_token(c);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sends one transaction, waits for it to be taken and records what it should produce.
  task automatic send_item(input logic [7:0] ch, input logic fl);
    int      gap;
    amount_t res;
    bit      was_idle;
    bit      got;
    if (pacing_on && ($urandom_range(0, 5) == 0)) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= ch;
    flush_i     <= fl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    was_idle = (tok_state == TOK_IDLE);
    got      = predict_amount(ch, fl, res);
    if (got) begin
      expected_amounts.push_back(res);
    end
    if (!(was_idle && !got && (tok_state == TOK_IDLE))) begin
      accepted_chars++;
    end
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_item(s[i], 1'b0);
    end
  endtask

  function automatic logic [7:0] digit_char(input int d);
    return CHAR_ZERO + d[7:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Bytes that cannot open a token, and a flush with nothing open, give no result.
  task automatic test_idle_noise();
    send_item(CHAR_POINT, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  // A sign ended by another sign, then a sign ended by a letter: zero with status.
  task automatic test_sign_only();
    send_text("-+x");
  endtask

  // Negative zero split from a following digit, then a point with no digits.
  task automatic test_zero_and_point();
    send_text("-05.");
    send_item(8'h00, 1'b1);
  endtask

  // The second fraction digit closes the token without a terminator.
  task automatic test_two_fraction_digits();
    send_text("9.99");
  endtask

  // Seventeen nines exceed the magnitude; a dropped byte then closes the token.
  task automatic test_overflow();
    int i;
    send_item(CHAR_MINUS, 1'b0);
    for (i = 0; i < 17; i++) begin
      send_item(CHAR_NINE, 1'b0);
    end
    send_item(8'hFF, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Random stream
  // ---------------------------------------------------------------------------

  task automatic send_noise();
    int n;
    int i;
    n = $urandom_range(1, 3);
    for (i = 0; i < n; i++) begin
      send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
    end
  endtask

  // Mostly well-formed amounts with random content and a random way of ending.
  task automatic send_random_token();
    string seps;
    int    pick;
    int    n_int;
    int    n_frac;
    int    i;
    seps = " ,;\n";
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      send_item(CHAR_MINUS, 1'b0);
    end else if (pick == 1) begin
      send_item(CHAR_PLUS, 1'b0);
    end
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      // The largest amount that fits, or just past it.
      send_text("92233720368547758.0");
      send_item(digit_char($urandom_range(6, 9)), 1'b0);
    end else begin
      if (pick < 6) begin
        n_int = 0;
      end else if (pick < 94) begin
        n_int = $urandom_range(1, 6);
      end else begin
        n_int = $urandom_range(15, 22);
      end
      for (i = 0; i < n_int; i++) begin
        send_item(digit_char($urandom_range(0, 9)), 1'b0);
      end
      if ($urandom_range(0, 9) < 6) begin
        send_item(CHAR_POINT, 1'b0);
        n_frac = $urandom_range(0, 2);
        if ($urandom_range(0, 15) == 0) begin
          n_frac = 3;
        end
        for (i = 0; i < n_frac; i++) begin
          send_item(digit_char($urandom_range(0, 9)), 1'b0);
        end
      end
    end
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end else if (pick < 6) begin
      send_item(seps[$urandom_range(0, seps.len() - 1)], 1'b0);
    end else if (pick < 8) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic test_random_tokens();
    while (accepted_chars < STREAM_ITEMS) begin
      if (accepted_chars > STREAM_ITEMS - CALM_TAIL) begin
        pacing_on = 1'b0;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end
      send_random_token();
    end
    // Close whatever token is still open.
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Back-pressure on the result channel in random bursts, with ready stretches between.
  initial begin : result_pacing
    int span;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pacing_on && ($urandom_range(0, 3) == 0)) begin
        span = $urandom_range(1, 11);
        out_ready_i <= 1'b0;
        repeat (span) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      span = $urandom_range(1, 40);
      repeat (span - 1) @(posedge clk_i);
    end
  end

  // Compares each result transaction with the oldest predicted amount.
  always @(posedge clk_i) begin : result_check
    amount_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_amounts.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("ERROR: result with none expected: cents %0d status %0d",
                   $signed(cents_o), status_o);
        end
      end else begin
        want = expected_amounts.pop_front();
        if ((cents_o !== want.cents) || (status_o !== want.status)) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("ERROR: cents expected %0d got %0d, status expected %0d got %0d",
                     $signed(want.cents), $signed(cents_o), want.status, status_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_noise();
    test_sign_only();
    test_zero_and_point();
    test_two_fraction_digits();
    test_overflow();
    test_random_tokens();
    in_valid_i <= 1'b0;
    while (expected_amounts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if ((error_count == 0) && (expected_amounts.size() == 0)) begin
      $display("PASS decimal_money_to_cents_parser");
    end else begin
      $display("FAIL decimal_money_to_cents_parser");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL decimal_money_to_cents_parser");
    $finish;
  end

endmodule
